// ===== hw/rtl/utf16_to_utf8_transcoder_macros.svh =====
// Assertion macros for the UTF-16 to UTF-8 transcoder.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define UTT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utt: same-cycle check failed");

`define UTT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utt: next-cycle check failed");

`else

`define UTT_ASSERT_IMP(lbl, ante, cons)

`define UTT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/utt_pkg.sv =====
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
package utt_pkg;

   localparam int FIFO_DEPTH = 2;

   localparam logic [7:0] REPL_BYTE = 8'h23;
   localparam logic [5:0] HIGH_PREFIX = 6'b110110;   // 0xD800..0xDBFF
   localparam logic [5:0] LOW_PREFIX  = 6'b110111;   // 0xDC00..0xDFFF

   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] CONT   = 8'h80;

   // one classified input word: up to four bytes ready to go out
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [3:0]      repl;
      logic [1:0]      count_m1;
      logic            str_last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ===== hw/rtl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   channel  direction  handshake            fields
//   req      in         req_valid/req_stall  req_code_unit[15:0], req_last_unit
//   rsp      out        rsp_valid/rsp_stall  rsp_out_byte[7:0], rsp_run_last,
//                                            rsp_string_last, rsp_is_replacement
//
// The front end takes one word per cycle while the job queue has room.
// The back end sends one byte per cycle unless stalled or the queue is empty; a word
// yields 1 to 4 bytes, a held high surrogate none. The output register sets the pace.
// Reset is synchronous and clears the pending surrogate, the queue and the output valid.
// rsp_stall holds the output register; the queue then fills and raises req_stall.
`include "utf16_to_utf8_transcoder_macros.svh"

module utf16_to_utf8_transcoder #(
   parameter int FIFO_DEPTH = utt_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_last,
   output logic        rsp_is_replacement
);

   utt_pkg::job_type       push_job, head_job;
   utt_pkg::fifo_stat_type q_stat;
   logic                   push, pop;

   utt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .q_stat        (q_stat),
      .push          (push),
      .job           (push_job)
   );

   utt_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   utt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .q_stat             (q_stat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_last    (rsp_string_last),
      .rsp_is_replacement (rsp_is_replacement)
   );

   // a word's bytes are queued as one job, so mid-word the next byte follows at once
   `UTT_ASSERT_NXT(a_run_continues, rsp_valid && !rsp_stall && !rsp_run_last, rsp_valid)
   `UTT_ASSERT_IMP(a_str_end_is_run_end, rsp_valid && rsp_string_last, rsp_run_last)
   `UTT_ASSERT_IMP(a_repl_byte, rsp_valid && rsp_is_replacement, rsp_out_byte == utt_pkg::REPL_BYTE)
   `UTT_ASSERT_IMP(a_no_push_when_full, q_stat.full, !push)

endmodule

// ===== hw/rtl/utt_front.sv =====
// Front end: accepts code units, tracks the pending high surrogate, builds byte jobs.
module utt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_code_unit,
   input  logic                   req_last_unit,
   input  utt_pkg::fifo_stat_type q_stat,
   output logic                   push,
   output utt_pkg::job_type       job
);

   logic       pend_ff, pend_in;
   logic [9:0] hbits_ff, hbits_in;

   logic        accept;
   logic        is_high, is_low;
   logic [20:0] cp4;
   logic [2:0][7:0] tbytes;
   logic [2:0]  trepl;
   logic [2:0]  tcount;
   logic [3:0][7:0] bytes;
   logic [3:0]  repl;
   logic [2:0]  count;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign is_high   = (req_code_unit[15:10] == utt_pkg::HIGH_PREFIX);
   assign is_low    = (req_code_unit[15:10] == utt_pkg::LOW_PREFIX);
   assign cp4       = {1'b0, hbits_ff, req_code_unit[9:0]} + 21'h10000;

   // bytes of the current unit taken on its own
   always_comb begin
      tbytes = '0;
      trepl  = '0;
      tcount = 3'd0;
      if (is_high) begin
         if (req_last_unit) begin
            tbytes[0] = utt_pkg::REPL_BYTE;
            trepl[0]  = 1'b1;
            tcount    = 3'd1;
         end
      end else if (is_low) begin
         tbytes[0] = utt_pkg::REPL_BYTE;
         trepl[0]  = 1'b1;
         tcount    = 3'd1;
      end else if (req_code_unit < 16'h0080) begin
         tbytes[0] = req_code_unit[7:0];
         tcount    = 3'd1;
      end else if (req_code_unit < 16'h0800) begin
         tbytes[0] = utt_pkg::LEAD_2 | {3'b000, req_code_unit[10:6]};
         tbytes[1] = utt_pkg::CONT | {2'b00, req_code_unit[5:0]};
         tcount    = 3'd2;
      end else begin
         tbytes[0] = utt_pkg::LEAD_3 | {4'b0000, req_code_unit[15:12]};
         tbytes[1] = utt_pkg::CONT | {2'b00, req_code_unit[11:6]};
         tbytes[2] = utt_pkg::CONT | {2'b00, req_code_unit[5:0]};
         tcount    = 3'd3;
      end
   end

   always_comb begin
      bytes = '0;
      repl  = '0;
      count = 3'd0;
      if (pend_ff && is_low) begin
         bytes[0] = utt_pkg::LEAD_4 | {5'b00000, cp4[20:18]};
         bytes[1] = utt_pkg::CONT | {2'b00, cp4[17:12]};
         bytes[2] = utt_pkg::CONT | {2'b00, cp4[11:6]};
         bytes[3] = utt_pkg::CONT | {2'b00, cp4[5:0]};
         count    = 3'd4;
      end else if (pend_ff) begin
         // orphaned high surrogate: '#' ahead of the current unit
         bytes[0]   = utt_pkg::REPL_BYTE;
         repl[0]    = 1'b1;
         bytes[3:1] = tbytes;
         repl[3:1]  = trepl;
         count      = tcount + 3'd1;
      end else begin
         bytes[2:0] = tbytes;
         repl[2:0]  = trepl;
         count      = tcount;
      end
   end

   assign push         = accept && (count != 3'd0);
   assign job.bytes    = bytes;
   assign job.repl     = repl;
   assign job.count_m1 = 2'(count - 3'd1);
   assign job.str_last = req_last_unit;

   always_comb begin
      pend_in  = pend_ff;
      hbits_in = hbits_ff;
      if (accept) begin
         if (is_high && !req_last_unit && !(pend_ff && is_low)) begin
            pend_in  = 1'b1;
            hbits_in = req_code_unit[9:0];
         end else begin
            pend_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      hbits_ff <= hbits_in;
   end

endmodule

// ===== hw/rtl/utt_fifo.sv =====
// Short job queue between front and back end.
module utt_fifo #(
   parameter int DEPTH = utt_pkg::FIFO_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  utt_pkg::job_type       push_job,
   input  logic                   pop,
   output utt_pkg::job_type       head_job,
   output utt_pkg::fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   utt_pkg::job_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/utt_back.sv =====
// Back end: sends queued job bytes via an output register, one per cycle unless stalled.
module utt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  utt_pkg::job_type       head_job,
   input  utt_pkg::fifo_stat_type q_stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_string_last,
   output logic                   rsp_is_replacement
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       run_last_ff, str_last_ff, repl_ff;

   logic load;
   logic at_end;

   assign load   = !q_stat.empty && (!valid_ff || !rsp_stall);
   assign at_end = (idx_ff == head_job.count_m1);
   assign pop    = load && at_end;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (load) begin
         byte_ff     <= head_job.bytes[idx_ff];
         repl_ff     <= head_job.repl[idx_ff];
         run_last_ff <= at_end;
         str_last_ff <= at_end && head_job.str_last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_run_last       = run_last_ff;
   assign rsp_string_last    = str_last_ff;
   assign rsp_is_replacement = repl_ff;

endmodule
